// ===== src/tcq_pkg.sv =====
// tcq_pkg: shared types and constants for the two-class oldest-first queue
// opcodes, status codes, transfer structs and the per-class memory entry
// no dependencies
`default_nettype none

package tcq_pkg;

  localparam int KEY_W            = 32;
  localparam int STAMP_W          = 16;
  localparam int DEFAULT_CAPACITY = 16;

  // opcodes
  localparam logic [1:0] OP_ENQ     = 2'd0;
  localparam logic [1:0] OP_DEQ_ANY = 2'd1;
  localparam logic [1:0] OP_DEQ_EVN = 2'd2;
  localparam logic [1:0] OP_DEQ_ODD = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [KEY_W-1:0] key_value;
  } tcq_cmd_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key_out;
    logic [1:0]              status;
  } tcq_result_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] stamp;
  } tcq_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } tcq_fifo_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } tcq_fifo_stat_t;

endpackage

`default_nettype wire

// ===== src/two_class_oldest_first_queue.sv =====
// two_class_oldest_first_queue: top level, command sequencer, arbitration, result register
// instantiates one tcq_class_fifo per class; depends on tcq_pkg
// a command is latched at transfer; its result and done are registered at the end of exec
// a new command is taken only after exec has ended, as the registered head read of both
//   class memories must land before the dequeue decision and write-back
// reset: pointers, fill counts, arrival counter and sequencer cleared; memories not
//   cleared and need no clearing pass; the receiver cannot stall, done lasts one cycle
`default_nettype none

module two_class_oldest_first_queue #(
  parameter int CAPACITY = tcq_pkg::DEFAULT_CAPACITY
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  output logic                 busy,
  input  tcq_pkg::tcq_cmd_t    cmd,
  output logic                 done,
  output tcq_pkg::tcq_result_t result
);

  // sequencer states: idle waits for a command, exec decides and writes back
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  // latched command
  logic [1:0]                       opcode;
  logic [tcq_pkg::KEY_W-1:0]        key;

  // arrival stamp for the next enqueue, wraps modulo 2^STAMP_W
  logic [tcq_pkg::STAMP_W-1:0]      arrival;

  tcq_pkg::tcq_fifo_ctl_t  ev_ctl, od_ctl;
  tcq_pkg::tcq_fifo_stat_t ev_stat, od_stat;
  tcq_pkg::tcq_entry_t     ev_head, od_head, wr_entry;

  logic                    accept;
  logic                    exec;
  logic                    even_older;
  logic [tcq_pkg::STAMP_W-1:0] stamp_diff;
  logic                    take_even, take_odd;
  logic                    push_even, push_odd;
  tcq_pkg::tcq_result_t    result_next;

  assign accept = start && !busy;
  assign busy   = (state == S_EXEC);
  assign exec   = (state == S_EXEC);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      arrival <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= exec;
      if (push_even || push_odd) arrival <= arrival + 1'b1;
    end
  end

  // command payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      opcode <= cmd.opcode;
      key    <= cmd.key_value;
    end
  end

  // heads are compared on stamp difference read as signed, so wrap is harmless
  assign stamp_diff = od_head.stamp - ev_head.stamp;
  assign even_older = !stamp_diff[tcq_pkg::STAMP_W-1];

  always_comb begin
    take_even   = 1'b0;
    take_odd    = 1'b0;
    push_even   = 1'b0;
    push_odd    = 1'b0;
    result_next = '0;
    unique case (opcode)
      tcq_pkg::OP_ENQ: begin
        if (key[0]) begin
          push_odd = exec && !od_stat.full;
          if (od_stat.full) result_next.status = tcq_pkg::ST_FULL;
        end else begin
          push_even = exec && !ev_stat.full;
          if (ev_stat.full) result_next.status = tcq_pkg::ST_FULL;
        end
      end
      tcq_pkg::OP_DEQ_EVN: begin
        take_even = !ev_stat.empty;
      end
      tcq_pkg::OP_DEQ_ODD: begin
        take_odd = !od_stat.empty;
      end
      tcq_pkg::OP_DEQ_ANY: begin
        // oldest of the two heads; a lone nonempty class wins outright
        take_even = !ev_stat.empty && (od_stat.empty || even_older);
        take_odd  = !od_stat.empty && (ev_stat.empty || !even_older);
      end
      default: ;
    endcase
    if (opcode != tcq_pkg::OP_ENQ) begin
      if (take_even) begin
        result_next.key_out = ev_head.key;
      end else if (take_odd) begin
        result_next.key_out = od_head.key;
      end else begin
        result_next.status = tcq_pkg::ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) result <= result_next;
  end

  // memory write-back and pointer updates land at the end of exec
  assign wr_entry.key   = key;
  assign wr_entry.stamp = arrival;
  assign ev_ctl.push    = push_even;
  assign ev_ctl.pop     = exec && take_even;
  assign od_ctl.push    = push_odd;
  assign od_ctl.pop     = exec && take_odd;

  tcq_class_fifo #(.CAPACITY(CAPACITY)) u_even (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ev_ctl),
    .wr_entry (wr_entry),
    .head     (ev_head),
    .stat     (ev_stat)
  );

  tcq_class_fifo #(.CAPACITY(CAPACITY)) u_odd (
    .clk      (clk),
    .rst      (rst),
    .ctl      (od_ctl),
    .wr_entry (wr_entry),
    .head     (od_head),
    .stat     (od_stat)
  );

  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ev_ctl.push, ev_ctl.pop, od_ctl.push, od_ctl.pop}))
    else $error("more than one queue action in a cycle");

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy ##1 !busy)
    else $error("exec phase not exactly one cycle");

  a_done_follows_exec: assert property (@(posedge clk) disable iff (rst)
    exec |=> done)
    else $error("missing result strobe after exec");

  a_fail_zero_key: assert property (@(posedge clk) disable iff (rst)
    done && result.status != tcq_pkg::ST_DONE |-> result.key_out == '0)
    else $error("nonzero key on a refused command");

endmodule

`default_nettype wire

// ===== src/tcq_class_fifo.sv =====
// tcq_class_fifo: one class queue, keys and arrival stamps in a synchronous memory
// read and write pointers, fill count, head entry read registered every cycle
// depends on tcq_pkg
`default_nettype none

module tcq_class_fifo #(
  parameter int CAPACITY = tcq_pkg::DEFAULT_CAPACITY
) (
  input  wire                    clk,
  input  wire                    rst,
  input  tcq_pkg::tcq_fifo_ctl_t ctl,
  input  tcq_pkg::tcq_entry_t    wr_entry,
  output tcq_pkg::tcq_entry_t    head,
  output tcq_pkg::tcq_fifo_stat_t stat
);

  localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  tcq_pkg::tcq_entry_t mem [CAPACITY];

  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] count;

  // memory port: one write, one registered read of the head slot
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr] <= wr_entry;
    end
    head <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (ctl.push) begin
        wr_ptr <= (wr_ptr == PTR_W'(CAPACITY - 1)) ? '0 : wr_ptr + 1'b1;
        count  <= count + 1'b1;
      end else if (ctl.pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(CAPACITY - 1)) ? '0 : rd_ptr + 1'b1;
        count  <= count - 1'b1;
      end
    end
  end

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(CAPACITY));

  a_no_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(ctl.push && ctl.pop))
    else $error("push and pop in the same cycle");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> !stat.full)
    else $error("push into a full class queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> !stat.empty)
    else $error("pop from an empty class queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

endmodule

`default_nettype wire

// ===== tb/tb_two_class_oldest_first_queue.sv =====
// tb_two_class_oldest_first_queue: self-checking bench for the two-class oldest-first queue
// clocked driver and monitor around a predictor of both class fifos and the arrival stamps
// depends on tcq_pkg and two_class_oldest_first_queue
module tb_two_class_oldest_first_queue;

  localparam int QDEPTH      = tcq_pkg::DEFAULT_CAPACITY;
  localparam int STALL_LIMIT = 4000;   // cycles with no transfer and no result
  localparam int CHURN_PAIRS = 64;     // enqueue and oldest-any pairs in the churn phase

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  tcq_pkg::tcq_cmd_t    cmd = '0;
  logic                 done;
  tcq_pkg::tcq_result_t result;

  two_class_oldest_first_queue uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  always #6 clk = ~clk;

  // commands waiting to be sent and results still owed by the block
  tcq_pkg::tcq_cmd_t    pending_cmds[$];
  tcq_pkg::tcq_result_t owed_results[$];

  int idle_pct = 0;
  int fail_count = 0;
  int cmds_sent = 0;
  int results_seen = 0;
  int full_refusals = 0;
  int empty_takes = 0;
  int stamp_wraps = 0;
  int stall_cycles = 0;

  // predicted contents of the two class fifos; index 0 even, 1 odd
  logic signed [tcq_pkg::KEY_W-1:0]   held_key   [2][QDEPTH];
  logic        [tcq_pkg::STAMP_W-1:0] held_stamp [2][QDEPTH];
  int                                 head_slot  [2] = '{0, 0};
  int                                 tail_slot  [2] = '{0, 0};
  int                                 fill       [2] = '{0, 0};
  logic        [tcq_pkg::STAMP_W-1:0] arrivals = '0;

  // applies one command to the predicted queue and returns what the block should answer
  function automatic tcq_pkg::tcq_result_t queue_outcome(tcq_pkg::tcq_cmd_t c);
    tcq_pkg::tcq_result_t r;
    int cls;
    logic [tcq_pkg::STAMP_W-1:0] gap;
    r.key_out = '0;
    r.status  = tcq_pkg::ST_DONE;
    cls = -1;
    if (c.opcode == tcq_pkg::OP_ENQ) begin
      cls = c.key_value[0];
      if (fill[cls] == QDEPTH) begin
        r.status = tcq_pkg::ST_FULL;
      end else begin
        held_key[cls][tail_slot[cls]]   = c.key_value;
        held_stamp[cls][tail_slot[cls]] = arrivals;
        tail_slot[cls] = (tail_slot[cls] + 1) % QDEPTH;
        fill[cls]++;
        arrivals++;
        if (arrivals == '0) stamp_wraps++;
      end
    end else begin
      case (c.opcode)
        tcq_pkg::OP_DEQ_EVN: if (fill[0] != 0) cls = 0;
        tcq_pkg::OP_DEQ_ODD: if (fill[1] != 0) cls = 1;
        default: begin
          if (fill[0] != 0 && fill[1] != 0) begin
            // stamps compared modulo 2^16: a negative difference means odd is older
            gap = held_stamp[1][head_slot[1]] - held_stamp[0][head_slot[0]];
            cls = gap[tcq_pkg::STAMP_W-1] ? 1 : 0;
          end else if (fill[0] != 0) begin
            cls = 0;
          end else if (fill[1] != 0) begin
            cls = 1;
          end
        end
      endcase
      if (cls < 0) begin
        r.status = tcq_pkg::ST_EMPTY;
      end else begin
        r.key_out = held_key[cls][head_slot[cls]];
        head_slot[cls] = (head_slot[cls] + 1) % QDEPTH;
        fill[cls]--;
      end
    end
    return r;
  endfunction

  // driver: start stays up until the transfer, then the next command may follow at once
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        owed_results.push_back(queue_outcome(cmd));
        void'(pending_cmds.pop_front());
        cmds_sent++;
      end
      if (start && busy) begin
        // hold the command until the block takes it
      end else if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        cmd   <= pending_cmds[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every strobed result is checked against the oldest owed one
  always @(posedge clk) begin
    tcq_pkg::tcq_result_t want;
    if (!rst && done) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        $display("%0t: result with none expected: key_out %0d status %0d",
                 $time, result.key_out, result.status);
        fail_count++;
      end else begin
        want = owed_results.pop_front();
        if (want.status == tcq_pkg::ST_FULL) full_refusals++;
        if (want.status == tcq_pkg::ST_EMPTY) empty_takes++;
        if (result.key_out !== want.key_out) begin
          $display("%0t: key_out mismatch: expected %0d, actual %0d",
                   $time, want.key_out, result.key_out);
          fail_count++;
        end
        if (result.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, result.status);
          fail_count++;
        end
      end
    end
  end

  // watchdog: gives up when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic queue_cmd(input logic [1:0] op, input logic signed [tcq_pkg::KEY_W-1:0] k);
    tcq_pkg::tcq_cmd_t c;
    c.opcode    = op;
    c.key_value = k;
    pending_cmds.push_back(c);
  endtask

  // mostly random keys of the wanted class, now and then a boundary value
  function automatic logic signed [tcq_pkg::KEY_W-1:0] pick_key(int odd_pct);
    logic signed [tcq_pkg::KEY_W-1:0] k;
    if ($urandom_range(15) == 0) begin
      case ($urandom_range(5))
        0: k = 32'sh7fffffff;
        1: k = 32'sh80000000;
        2: k = 0;
        3: k = -1;
        4: k = 1;
        default: k = -2;
      endcase
    end else begin
      k = $urandom;
      k[0] = ($urandom_range(99) < odd_pct);
    end
    return k;
  endfunction

  function automatic logic [1:0] pick_take();
    case ($urandom_range(2))
      0: return tcq_pkg::OP_DEQ_ANY;
      1: return tcq_pkg::OP_DEQ_EVN;
      default: return tcq_pkg::OP_DEQ_ODD;
    endcase
  endfunction

  // random bursts with their own enqueue and class bias, so fill levels swing
  // from empty to full in each class
  task automatic queue_random(input int n);
    int made;
    int burst;
    int enq_pct;
    int odd_pct;
    made = 0;
    while (made < n) begin
      burst = $urandom_range(10, 60);
      case ($urandom_range(2))
        0: enq_pct = 85;
        1: enq_pct = 50;
        default: enq_pct = 25;
      endcase
      case ($urandom_range(4))
        0: odd_pct = 0;
        1: odd_pct = 100;
        2: odd_pct = 30;
        3: odd_pct = 70;
        default: odd_pct = 50;
      endcase
      for (int i = 0; i < burst && made < n; i++) begin
        if ($urandom_range(99) < enq_pct) queue_cmd(tcq_pkg::OP_ENQ, pick_key(odd_pct));
        else queue_cmd(pick_take(), pick_key(50));
        made++;
      end
    end
  endtask

  task automatic drain_all();
    while (pending_cmds.size() != 0 || owed_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_phase(input int pct);
    @(negedge clk);
    idle_pct = pct;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty takes, boundary keys, arbitration by age, last key, missing class
    set_phase(0);
    queue_cmd(tcq_pkg::OP_DEQ_ANY, 32'sh7fffffff);
    queue_cmd(tcq_pkg::OP_DEQ_EVN, 0);
    queue_cmd(tcq_pkg::OP_DEQ_ODD, -1);
    queue_cmd(tcq_pkg::OP_ENQ, 32'sh7fffffff);
    queue_cmd(tcq_pkg::OP_ENQ, 32'sh80000000);
    queue_cmd(tcq_pkg::OP_ENQ, 0);
    queue_cmd(tcq_pkg::OP_ENQ, -1);
    queue_cmd(tcq_pkg::OP_ENQ, 1);
    queue_cmd(tcq_pkg::OP_DEQ_EVN, 0);
    queue_cmd(tcq_pkg::OP_DEQ_ANY, 0);
    queue_cmd(tcq_pkg::OP_DEQ_ODD, 0);
    queue_cmd(tcq_pkg::OP_DEQ_ANY, 0);
    queue_cmd(tcq_pkg::OP_DEQ_ANY, 0);
    queue_cmd(tcq_pkg::OP_DEQ_ANY, 0);
    queue_cmd(tcq_pkg::OP_ENQ, 2);
    queue_cmd(tcq_pkg::OP_DEQ_ODD, 0);
    queue_cmd(tcq_pkg::OP_DEQ_ANY, 0);
    drain_all();

    // random traffic: back to back, sparse sender, light gaps
    set_phase(0);
    queue_random(350);
    drain_all();
    set_phase(83);
    queue_random(350);
    drain_all();
    set_phase(10);
    queue_random(400);
    drain_all();

    // churn with a few keys of each class live while oldest-any picks between the heads
    set_phase(0);
    for (int i = 0; i < 3; i++) begin
      queue_cmd(tcq_pkg::OP_ENQ, pick_key(0));
      queue_cmd(tcq_pkg::OP_ENQ, pick_key(100));
    end
    for (int i = 0; i < CHURN_PAIRS; i++) begin
      queue_cmd(tcq_pkg::OP_ENQ, pick_key(50));
      queue_cmd(tcq_pkg::OP_DEQ_ANY, pick_key(50));
    end
    drain_all();

    repeat (10) @(posedge clk);
    $display("covered %0d commands and %0d results, %0d refused as full,",
             cmds_sent, results_seen, full_refusals);
    $display("%0d with nothing to take, arrival stamps wrapped %0d time(s)",
             empty_takes, stamp_wraps);
    if (fail_count == 0 && owed_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tcq_pkg.sv
src/tcq_class_fifo.sv
src/two_class_oldest_first_queue.sv
tb/tb_two_class_oldest_first_queue.sv
